// File: sv/edsp_pkg.sv
// ----------------------------------------------------------------------------
// edsp_pkg
// Shared types and constants of the lax DER signature parser: tag values,
// group order, status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package edsp_pkg;

	localparam logic [7:0] SEQ_TAG = 8'h30;
	localparam logic [7:0] INT_TAG = 8'h02;

	localparam logic [5:0] MAX_SIG_BYTES = 6'd32;

	localparam logic [255:0] GROUP_ORDER =
		256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFE_BAAEDCE6AF48A03B_BFD25E8CD0364141;

	localparam logic [1:0] ST_FAIL     = 2'd0;
	localparam logic [1:0] ST_VALID    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		OP_SEQ_TAG  = 3'd0,
		OP_SEQ_LEN  = 3'd1,
		OP_SEQ_SKIP = 3'd2,
		OP_INT_TAG  = 3'd3,
		OP_INT_LEN  = 3'd4,
		OP_INT_DIG  = 3'd5,
		OP_INT_BODY = 3'd6,
		OP_IDLE     = 3'd7
	} op_t;

	typedef struct packed {
		logic       take;
		op_t        op;
		logic       is_s;
		logic       eval;
		logic       parse_done;
		logic       clear;
		logic [2:0] word_sel;
	} cmd_t;

	typedef struct packed {
		logic tag_ok;
		logic long_digits;
		logic digits_one;
		logic len_zero;
		logic bytes_one;
		logic dig_fail;
		logic failed;
	} sts_t;

endpackage

// File: sv/edsp_dpath.sv
// ----------------------------------------------------------------------------
// edsp_dpath
// Parser datapath: length and digit counters, leading-zero strip, R and S
// shift registers, range check against the group order, output word select.
// ----------------------------------------------------------------------------
module edsp_dpath #(
	parameter int LENGTH_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  edsp_pkg::cmd_t   cmd,
	output edsp_pkg::sts_t   sts,
	output logic [1:0]       status,
	output logic [63:0]      sig_word
);
	import edsp_pkg::*;

	localparam int MaxDigits = LENGTH_BITS / 8;

	logic [LENGTH_BITS-1:0] bytes_q;
	logic [LENGTH_BITS-1:0] bytes_shift;
	logic [LENGTH_BITS-1:0] bytes_dig;
	logic [6:0]             digits_q;
	logic [5:0]             cnt_q;
	logic                   lz_q;
	logic [255:0]           r_q;
	logic [255:0]           s_q;
	logic                   ovf_q;
	logic                   fail_q;
	logic [1:0]             status_q;
	logic                   signif;
	logic [255:0]           src;
	logic [63:0]            word;

	always_comb begin
		signif      = (data_byte != 8'h00) || !lz_q;
		bytes_shift = (bytes_q << 8) | LENGTH_BITS'(data_byte);
		bytes_dig   = signif ? bytes_shift : bytes_q;

		sts.tag_ok      = (cmd.op == OP_SEQ_TAG) ? (data_byte == SEQ_TAG)
		                                         : (data_byte == INT_TAG);
		sts.long_digits = data_byte[7] && (data_byte[6:0] != 7'd0);
		sts.digits_one  = (digits_q == 7'd1);
		sts.bytes_one   = (bytes_q == LENGTH_BITS'(1));
		sts.dig_fail    = signif && (cnt_q >= 6'(MaxDigits));
		sts.failed      = fail_q;
		if (cmd.op == OP_INT_DIG) begin
			sts.len_zero = (bytes_dig == '0);
		end else begin
			sts.len_zero = data_byte[7] || (data_byte == 8'h00);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q  <= '0;
			digits_q <= '0;
			cnt_q    <= '0;
			lz_q     <= 1'b1;
			r_q      <= '0;
			s_q      <= '0;
			ovf_q    <= 1'b0;
			fail_q   <= 1'b0;
			status_q <= ST_FAIL;
		end else if (cmd.clear) begin
			bytes_q  <= '0;
			digits_q <= '0;
			cnt_q    <= '0;
			lz_q     <= 1'b1;
			r_q      <= '0;
			s_q      <= '0;
			ovf_q    <= 1'b0;
			fail_q   <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (fail_q || !cmd.parse_done) begin
					status_q <= ST_FAIL;
				end else if (ovf_q || (r_q >= GROUP_ORDER) || (s_q >= GROUP_ORDER)) begin
					status_q <= ST_OVERFLOW;
				end else begin
					status_q <= ST_VALID;
				end
			end
			if (cmd.take) begin
				case (cmd.op)
					OP_SEQ_TAG, OP_INT_TAG: begin
						if (!sts.tag_ok) fail_q <= 1'b1;
					end
					OP_SEQ_LEN: begin
						if (sts.long_digits) digits_q <= data_byte[6:0];
					end
					OP_SEQ_SKIP: begin
						digits_q <= digits_q - 7'd1;
					end
					OP_INT_LEN: begin
						bytes_q  <= data_byte[7] ? '0 : LENGTH_BITS'(data_byte);
						digits_q <= data_byte[6:0];
						cnt_q    <= '0;
						lz_q     <= 1'b1;
					end
					OP_INT_DIG: begin
						digits_q <= digits_q - 7'd1;
						if (signif) begin
							if (sts.dig_fail) fail_q <= 1'b1;
							else bytes_q <= bytes_shift;
						end
						// length complete: rearm the strip for the value body
						if (sts.digits_one && !sts.dig_fail) begin
							cnt_q <= '0;
							lz_q  <= 1'b1;
						end else if (signif) begin
							lz_q  <= 1'b0;
							cnt_q <= cnt_q + 6'd1;
						end
					end
					OP_INT_BODY: begin
						bytes_q <= bytes_q - LENGTH_BITS'(1);
						if (signif) begin
							lz_q <= 1'b0;
							if (cnt_q < MAX_SIG_BYTES) begin
								if (cmd.is_s) s_q <= {s_q[247:0], data_byte};
								else r_q <= {r_q[247:0], data_byte};
								cnt_q <= cnt_q + 6'd1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		src = cmd.word_sel[2] ? s_q : r_q;
		case (cmd.word_sel[1:0])
			2'd0:    word = src[255:192];
			2'd1:    word = src[191:128];
			2'd2:    word = src[127:64];
			default: word = src[63:0];
		endcase
	end

	assign status   = status_q;
	assign sig_word = (status_q == ST_VALID) ? word : 64'd0;

endmodule

// File: sv/edsp_ctrl.sv
// ----------------------------------------------------------------------------
// edsp_ctrl
// Parser controller: tracks the DER parse phase, sequences the status
// evaluation and the eight-word result burst, and drives both handshakes.
// ----------------------------------------------------------------------------
module edsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_byte,
	input  logic           out_stall,
	input  edsp_pkg::sts_t sts,
	output logic           in_stall,
	output logic           out_valid,
	output logic [2:0]     word_index,
	output logic           last_word,
	output edsp_pkg::cmd_t cmd
);
	import edsp_pkg::*;

	typedef enum logic [11:0] {
		PH_SEQ_TAG  = 12'b0000_0000_0001,
		PH_SEQ_LEN  = 12'b0000_0000_0010,
		PH_SEQ_SKIP = 12'b0000_0000_0100,
		PH_R_TAG    = 12'b0000_0000_1000,
		PH_R_LEN    = 12'b0000_0001_0000,
		PH_R_DIG    = 12'b0000_0010_0000,
		PH_R_BODY   = 12'b0000_0100_0000,
		PH_S_TAG    = 12'b0000_1000_0000,
		PH_S_LEN    = 12'b0001_0000_0000,
		PH_S_DIG    = 12'b0010_0000_0000,
		PH_S_BODY   = 12'b0100_0000_0000,
		PH_DONE     = 12'b1000_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		M_RUN  = 3'b001,
		M_EVAL = 3'b010,
		M_EMIT = 3'b100
	} mode_t;

	phase_t     phase_q, phase_d;
	mode_t      mode_q, mode_d;
	logic [2:0] word_q, word_d;
	logic       accept;

	always_comb begin
		accept   = in_valid && (mode_q == M_RUN);
		cmd.take = accept && !sts.failed;
		cmd.is_s = phase_q inside {PH_S_TAG, PH_S_LEN, PH_S_DIG, PH_S_BODY, PH_DONE};
		case (phase_q)
			PH_SEQ_TAG:          cmd.op = OP_SEQ_TAG;
			PH_SEQ_LEN:          cmd.op = OP_SEQ_LEN;
			PH_SEQ_SKIP:         cmd.op = OP_SEQ_SKIP;
			PH_R_TAG, PH_S_TAG:  cmd.op = OP_INT_TAG;
			PH_R_LEN, PH_S_LEN:  cmd.op = OP_INT_LEN;
			PH_R_DIG, PH_S_DIG:  cmd.op = OP_INT_DIG;
			PH_R_BODY, PH_S_BODY: cmd.op = OP_INT_BODY;
			default:             cmd.op = OP_IDLE;
		endcase
		cmd.eval       = (mode_q == M_EVAL);
		cmd.parse_done = (phase_q == PH_DONE);
		cmd.clear      = (mode_q == M_EMIT) && !out_stall && (word_q == 3'd7);
		cmd.word_sel   = word_q;
	end

	// next parse phase for the byte at hand
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SEQ_TAG: if (sts.tag_ok) phase_d = PH_SEQ_LEN;
			PH_SEQ_LEN: phase_d = sts.long_digits ? PH_SEQ_SKIP : PH_R_TAG;
			PH_SEQ_SKIP: if (sts.digits_one) phase_d = PH_R_TAG;
			PH_R_TAG: if (sts.tag_ok) phase_d = PH_R_LEN;
			PH_S_TAG: if (sts.tag_ok) phase_d = PH_S_LEN;
			PH_R_LEN: begin
				if (sts.long_digits) phase_d = PH_R_DIG;
				else phase_d = sts.len_zero ? PH_S_TAG : PH_R_BODY;
			end
			PH_S_LEN: begin
				if (sts.long_digits) phase_d = PH_S_DIG;
				else phase_d = sts.len_zero ? PH_DONE : PH_S_BODY;
			end
			PH_R_DIG: begin
				if (!sts.dig_fail && sts.digits_one)
					phase_d = sts.len_zero ? PH_S_TAG : PH_R_BODY;
			end
			PH_S_DIG: begin
				if (!sts.dig_fail && sts.digits_one)
					phase_d = sts.len_zero ? PH_DONE : PH_S_BODY;
			end
			PH_R_BODY: if (sts.bytes_one) phase_d = PH_S_TAG;
			PH_S_BODY: if (sts.bytes_one) phase_d = PH_DONE;
			default: phase_d = phase_q;
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		word_d = word_q;
		case (mode_q)
			M_RUN: if (accept && last_byte) mode_d = M_EVAL;
			M_EVAL: mode_d = M_EMIT;
			M_EMIT: begin
				if (!out_stall) begin
					word_d = word_q + 3'd1;
					if (word_q == 3'd7) mode_d = M_RUN;
				end
			end
			default: mode_d = M_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			mode_q  <= M_RUN;
			word_q  <= 3'd0;
		end else begin
			mode_q <= mode_d;
			word_q <= word_d;
			if (cmd.clear) phase_q <= PH_SEQ_TAG;
			else if (cmd.take) phase_q <= phase_d;
		end
	end

	assign in_stall   = (mode_q != M_RUN);
	assign out_valid  = (mode_q == M_EMIT);
	assign word_index = word_q;
	assign last_word  = (word_q == 3'd7);

endmodule

// File: sv/ecdsa_der_signature_lax_parser.sv
// Sequence: after the last byte is taken, the controller passes through the
// evaluation state and then offers the result words.
// Throughput: one byte per cycle while parsing; after the last byte in_stall holds
// the input through evaluation and the eight-word burst; out_stall can prolong it.
// Evaluation registers status from the 256-bit compares of R and S against the order.
// Reset (arst_n low, asynchronous) rearms the parser and clears R, S and all flags.
// ----------------------------------------------------------------------------
// ecdsa_der_signature_lax_parser
// Lax DER signature parser: bytes in, eight 64-bit R||S words with status out.
// ----------------------------------------------------------------------------
module ecdsa_der_signature_lax_parser #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  word_index,
	output logic [63:0] sig_word,
	output logic        last_word
);
	import edsp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	edsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_byte  (last_byte),
		.out_stall  (out_stall),
		.sts        (sts),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.word_index (word_index),
		.last_word  (last_word),
		.cmd        (cmd)
	);

	edsp_dpath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.status    (status),
		.sig_word  (sig_word)
	);

`ifndef SYNTH
	a_no_input_during_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during result burst");

	a_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_VALID) |-> (sig_word == 64'd0))
		else $error("nonzero word on failed or overflowed signature");

	a_last_byte_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall && !out_valid)
		else $error("final byte did not start evaluation");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_word |=> !out_valid && !in_stall)
		else $error("burst did not end after eighth word");

	a_status_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> $stable(status))
		else $error("status changed within a burst");
`endif

endmodule
